// ===== src/mgrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Min gap and range tracker package
// Shared types and constants for the tracker and its gap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mgrt_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 11;
   localparam int COUNT_W = 11;

   // Register map: one 32-bit register, decoded on the word address bit.
   localparam int          CSR_AW       = 3;
   localparam logic [0:0]  CSR_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SPAN
   } mgrt_state_type;

endpackage

`default_nettype wire

// ===== src/mgrt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mgrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/mgrt_gap_unit.sv =====
// ----------------------------------------------------------------------------
// Gap unit
// Exact unsigned magnitude of the difference of two signed words, and a
// compare of that magnitude against the best gap so far.
// ----------------------------------------------------------------------------
`default_nettype none

module mgrt_gap_unit import mgrt_pkg::*; (
   input  wire logic signed [VALUE_W-1:0] op_a,
   input  wire logic signed [VALUE_W-1:0] op_b,
   input  wire logic        [VALUE_W-1:0] best,
   output logic             [VALUE_W-1:0] gap,
   output logic                           smaller
);

   logic a_ge_b;

   always_comb begin
      a_ge_b = (op_a >= op_b);
      // Modulo-2^32 subtraction gives the exact magnitude once ordered
      gap     = a_ge_b ? (VALUE_W'(op_a) - VALUE_W'(op_b))
                       : (VALUE_W'(op_b) - VALUE_W'(op_a));
      smaller = (gap < best);
   end

endmodule

`default_nettype wire

// ===== src/min_gap_and_range_tracker_unit.sv =====
// Sequencing: an accepted value is scanned against every stored value and
//   then appended; a rejected value skips the scan. A new value is taken
//   only once the previous result has been loaded into the result register.
//   The scan reads the store one entry per cycle through one gap unit.
// Reset: synchronous; clears the count and range, sets the best gap to all ones and capacity to 1024.
// ----------------------------------------------------------------------------
// Min gap and range tracker
// Stores signed values up to a capacity, tracks the smallest pairwise gap
// and the overall range, and answers one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module min_gap_and_range_tracker_unit import mgrt_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // input items
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [VALUE_W-1:0] req_value,
   // result items
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_status,
   output logic             [COUNT_W-1:0] rsp_stored_count,
   output logic                           rsp_span_valid,
   output logic             [VALUE_W-1:0] rsp_shortest_span,
   output logic             [VALUE_W-1:0] rsp_longest_span,
   // configuration
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic        [CSR_AW-1:0]  csr_paddr,
   input  wire logic        [31:0]        csr_pwdata,
   output logic             [31:0]        csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = CW + CAP_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] TWO_CNT = CW'(2);

   mgrt_state_type state_ff, state_in;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] small_ff, small_in;
   logic signed [VALUE_W-1:0] large_ff, large_in;
   logic        [VALUE_W-1:0] best_ff, best_in;
   logic        [CW-1:0]      count_ff, count_in;
   logic        [CW-1:0]      idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic                      status_ff, status_in;
   logic        [CAP_W-1:0]   cap_ff, cap_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_status_ff;
   logic        [COUNT_W-1:0] rsp_count_ff;
   logic                      rsp_span_valid_ff;
   logic        [VALUE_W-1:0] rsp_short_ff;
   logic        [VALUE_W-1:0] rsp_long_ff;

   logic                      ram_we;
   logic                      ram_re;
   logic        [VALUE_W-1:0] ram_rd_data;

   logic signed [VALUE_W-1:0] gap_a;
   logic signed [VALUE_W-1:0] gap_b;
   logic        [VALUE_W-1:0] gap;
   logic                      gap_smaller;

   logic                      csr_wr;
   logic                      store_full;
   logic                      span_ok;
   logic                      load_rsp;
   logic        [XW-1:0]      count_ext;
   logic        [XW-1:0]      cap_ext;
   logic        [CW+COUNT_W-1:0] count_wide;

   mgrt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (VALUE_W'(value_ff)),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   mgrt_gap_unit u_gap (
      .op_a    (gap_a),
      .op_b    (gap_b),
      .best    (best_ff),
      .gap     (gap),
      .smaller (gap_smaller)
   );

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && (csr_paddr[CSR_AW-1:2] == CSR_CAPACITY)) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
      if (csr_paddr[CSR_AW-1:2] == CSR_CAPACITY) begin
         csr_prdata = {{(32-CAP_W){1'b0}}, cap_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_comb begin
      count_ext  = {{CAP_W{1'b0}}, count_ff};
      cap_ext    = {{CW{1'b0}}, cap_ff};
      store_full = (count_ext >= cap_ext) || (count_ff >= MAX_CNT);
      span_ok    = (count_ff >= TWO_CNT);
      count_wide = {{COUNT_W{1'b0}}, count_ff};
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      small_in  = small_ff;
      large_in  = large_ff;
      best_in   = best_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      gap_a     = value_ff;
      gap_b     = signed'(ram_rd_data);
      load_rsp  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               idx_in   = '0;
               if (store_full) begin
                  status_in = 1'b1;
                  state_in  = ST_SPAN;
               end else begin
                  status_in = 1'b0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle; its data is compared the cycle after
            if (idx_ff < count_ff) begin
               ram_re  = 1'b1;
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && gap_smaller) begin
               best_in = gap;
            end
            if (!(idx_ff < count_ff) && !pend_ff) begin
               // Scan drained: append the value and widen the range
               ram_we = 1'b1;
               if (count_ff == '0) begin
                  small_in = value_ff;
                  large_in = value_ff;
               end else begin
                  if (value_ff < small_ff) begin
                     small_in = value_ff;
                  end
                  if (value_ff > large_ff) begin
                     large_in = value_ff;
                  end
               end
               count_in = count_ff + CW'(1);
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            gap_a = large_ff;
            gap_b = small_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         small_ff     <= '0;
         large_ff     <= '0;
         best_ff      <= '1;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         status_ff    <= 1'b0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         small_ff     <= small_in;
         large_ff     <= large_in;
         best_ff      <= best_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         status_ff    <= status_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_count_ff      <= count_wide[COUNT_W-1:0];
         rsp_span_valid_ff <= span_ok;
         rsp_short_ff      <= span_ok ? best_ff : '0;
         rsp_long_ff       <= span_ok ? gap : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_stored_count  = rsp_count_ff;
   assign rsp_span_valid    = rsp_span_valid_ff;
   assign rsp_shortest_span = rsp_short_ff;
   assign rsp_longest_span  = rsp_long_ff;

   // Checks
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("stored count beyond store depth");

   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> best_ff <= $past(best_ff))
      else $error("best gap grew");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append without count advance");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_span_valid_ff) |-> rsp_short_ff <= rsp_long_ff)
      else $error("shortest span above longest span");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store read and append in one cycle");

endmodule

`default_nettype wire

// ===== dv/gap_range_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gap and range checker
// Watches the item, result and register ports of the tracker, keeps its own
// copy of the stored set and predicts each result, then compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------

module gap_range_checker import mgrt_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic                      rsp_status,
   input  wire logic        [COUNT_W-1:0] rsp_stored_count,
   input  wire logic                      rsp_span_valid,
   input  wire logic        [VALUE_W-1:0] rsp_shortest_span,
   input  wire logic        [VALUE_W-1:0] rsp_longest_span,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic        [CSR_AW-1:0]  csr_paddr,
   input  wire logic        [31:0]        csr_pwdata,
   input  wire logic        [31:0]        csr_prdata,
   input  wire logic                      csr_pready,
   output int                             mismatches,
   output int                             outstanding
);

   typedef struct packed {
      logic               status;
      logic [COUNT_W-1:0] stored_count;
      logic               span_valid;
      logic [VALUE_W-1:0] shortest_span;
      logic [VALUE_W-1:0] longest_span;
   } tally_type;

   logic signed [VALUE_W-1:0] held [MAX_ENTRIES];
   int unsigned               held_count;
   logic signed [VALUE_W-1:0] low_mark;
   logic signed [VALUE_W-1:0] high_mark;
   logic        [VALUE_W-1:0] closest_gap;
   logic        [CAP_W-1:0]   capacity;
   tally_type                 awaited_tallies[$];

   function automatic logic [VALUE_W-1:0] distance(input logic signed [VALUE_W-1:0] a,
                                                    input logic signed [VALUE_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Add one value to the set and work out the result it should give.
   function automatic tally_type fold_in_value(input logic signed [VALUE_W-1:0] v);
      tally_type   t;
      int unsigned limit;
      int unsigned k;
      limit = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
      t.status = (held_count >= limit);
      if (!t.status) begin
         for (k = 0; k < held_count; k++) begin
            if (distance(v, held[k]) < closest_gap)
               closest_gap = distance(v, held[k]);
         end
         if (held_count == 0) begin
            low_mark  = v;
            high_mark = v;
         end else begin
            if (v < low_mark)
               low_mark = v;
            if (v > high_mark)
               high_mark = v;
         end
         held[held_count] = v;
         held_count++;
      end
      t.stored_count = held_count[COUNT_W-1:0];
      t.span_valid   = (held_count >= 2);
      t.shortest_span = t.span_valid ? closest_gap : '0;
      t.longest_span  = t.span_valid ? distance(high_mark, low_mark) : '0;
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         mismatches  = 0;
         held_count  = 0;
         low_mark    = '0;
         high_mark   = '0;
         closest_gap = '1;
         capacity    = CAP_RESET;
         awaited_tallies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_tallies.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatches++;
            end else begin
               want = awaited_tallies.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("stored_count", 32'(want.stored_count),
                           32'(rsp_stored_count));
               check_field("span_valid", 32'(want.span_valid), 32'(rsp_span_valid));
               check_field("shortest_span", want.shortest_span, rsp_shortest_span);
               check_field("longest_span", want.longest_span, rsp_longest_span);
            end
         end
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[CSR_AW-1:2] == CSR_CAPACITY) begin
            if (csr_pwrite)
               capacity = csr_pwdata[CAP_W-1:0];
            else
               check_field("capacity", {{(32-CAP_W){1'b0}}, capacity}, csr_prdata);
         end
         if (req_valid && req_ready)
            awaited_tallies = {awaited_tallies, fold_in_value(req_value)};
      end
      outstanding = awaited_tallies.size();
   end

endmodule

// ===== dv/min_gap_and_range_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min gap and range tracker testbench
// Drives values into the tracker through corner cases and random phases with
// varied capacities, idling and back-pressure; a separate checker predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------

module min_gap_and_range_tracker_unit_tb import mgrt_pkg::*; ();

   localparam int RUN_LIMIT = 5_000_000;
   localparam int LONG_HOLD = 3000;
   localparam logic [CSR_AW-1:0] CAPACITY_ADDR = {CSR_CAPACITY, 2'b00};

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_status;
   logic        [COUNT_W-1:0] rsp_stored_count;
   logic                      rsp_span_valid;
   logic        [VALUE_W-1:0] rsp_shortest_span;
   logic        [VALUE_W-1:0] rsp_longest_span;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic        [CSR_AW-1:0]  csr_paddr;
   logic        [31:0]        csr_pwdata;
   logic        [31:0]        csr_prdata;
   logic                      csr_pready;

   int          mismatches;
   int          outstanding;
   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   bit          hold_request  = 1'b0;
   bit          hold_served   = 1'b0;
   int unsigned cycle_count   = 0;
   logic [VALUE_W-1:0] last_sent = '0;

   min_gap_and_range_tracker_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_span_valid    (rsp_span_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   gap_range_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_span_valid    (rsp_span_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("min_gap_and_range_tracker_unit_tb: FAIL");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold that fills the block up.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Hold valid and the value until the item is taken; drop valid only while idling.
   task automatic offer_value(input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      last_sent  = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Withdraw the taken item, then wait for every result to come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Write the capacity, upper bits random, then read it back.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      logic [31:0] word;
      word = $urandom();
      word[CAP_W-1:0] = cap;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly full-range values; some land close to the last one to pull the gap down.
   function automatic logic [VALUE_W-1:0] pick_value(input int unsigned spread);
      logic [VALUE_W-1:0] step;
      if ($urandom_range(99) < 75)
         return $urandom();
      step = $urandom_range(spread, 1);
      return $urandom_range(1) ? last_sent + step : last_sent - step;
   endfunction

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int items,
                            input int unsigned send_pct, input int unsigned take_pct,
                            input int unsigned spread);
      int n;
      drain();
      write_capacity(cap);
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      for (n = 0; n < items; n++) begin
         if (n == items / 2 && take_pct == 0)
            hold_request = 1'b1;
         // pause the sender until every result is back
         if (n == items / 2 && send_pct > take_pct)
            drain();
         offer_value(pick_value(spread));
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] corner_values [6];
      logic [VALUE_W-1:0] tail_values [3];
      corner_values = '{32'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000,
                        32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      // minus one and one sit next to the stored zero; zero again gives a zero gap
      tail_values   = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // capacity zero rejects everything
      write_capacity(11'd0);
      offer_value(32'h0000_0001);
      offer_value(32'h8000_0000);
      // capacity one: first value taken, the next rejected
      drain();
      write_capacity(11'd1);
      offer_value(32'h8000_0000);
      offer_value(32'h7FFF_FFFF);
      // capacity above the store size saturates
      drain();
      write_capacity(11'h7FF);
      foreach (corner_values[k])
         offer_value(corner_values[k]);
      // capacity lowered below the count keeps the set and rejects
      drain();
      write_capacity(11'd4);
      offer_value($urandom());
      offer_value($urandom());

      run_phase(11'd170,  190, 10, 51, 1 << 20);
      run_phase(11'd5,    20,  51, 10, 1 << 12);
      run_phase(11'h7FF,  190, 51, 10, 1 << 12);
      run_phase(11'd1024, 180, 0,  0,  64);
      foreach (tail_values[k])
         offer_value(tail_values[k]);
      repeat (4) offer_value(pick_value(16));

      drain();
      repeat (40) @(negedge clock);
      if (mismatches == 0)
         $display("min_gap_and_range_tracker_unit_tb: PASS");
      else
         $display("min_gap_and_range_tracker_unit_tb: FAIL");
      $finish;
   end

endmodule

// ===== min_gap_and_range_tracker_unit.f =====
src/mgrt_pkg.sv
src/mgrt_ram.sv
src/mgrt_gap_unit.sv
src/min_gap_and_range_tracker_unit.sv
dv/gap_range_checker.sv
dv/min_gap_and_range_tracker_unit_tb.sv
